// ----- design/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debounce event queue package
// Shared operation codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
package bdq_pkg;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_KEY   = 3'd2,
    OP_POP   = 3'd3,
    OP_CLEAR = 3'd4,
    OP_QUERY = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic scan_clr;
    logic scan_inc;
    logic do_alloc;
    logic do_free;
    logic do_key;
    logic do_pop_rd;
    logic do_pop;
    logic do_clear;
    logic do_query;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    op_e  op;
    logic hit;
    logic scan_last;
    logic ring_empty;
  } stat_t;

endpackage

// ----- design/bdq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- design/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Button debounce event queue controller
// Sequences each operation and issues datapath commands.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bdq_pkg::stat_t stat_i,
  output bdq_pkg::ctrl_t ctrl_o,
  output logic          busy_o
);
  bdq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bdq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bdq_pkg::ST_IDLE: begin
        if (start_i) state_d = bdq_pkg::ST_CHECK;
      end
      bdq_pkg::ST_CHECK: begin
        case (stat_i.op)
          bdq_pkg::OP_ALLOC, bdq_pkg::OP_KEY: state_d = bdq_pkg::ST_SCAN;
          bdq_pkg::OP_POP: state_d = stat_i.ring_empty ? bdq_pkg::ST_DONE : bdq_pkg::ST_POP;
          default: state_d = bdq_pkg::ST_DONE;
        endcase
      end
      bdq_pkg::ST_SCAN: begin
        if (stat_i.hit || stat_i.scan_last) state_d = bdq_pkg::ST_DONE;
      end
      bdq_pkg::ST_POP: state_d = bdq_pkg::ST_DONE;
      bdq_pkg::ST_DONE: state_d = bdq_pkg::ST_IDLE;
      default: state_d = bdq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    busy_o = (state_q != bdq_pkg::ST_IDLE);
    case (state_q)
      bdq_pkg::ST_IDLE: ctrl_o.latch = start_i;
      bdq_pkg::ST_CHECK: begin
        ctrl_o.scan_clr = 1'b1;
        case (stat_i.op)
          bdq_pkg::OP_FREE:  ctrl_o.do_free = 1'b1;
          bdq_pkg::OP_CLEAR: ctrl_o.do_clear = 1'b1;
          bdq_pkg::OP_QUERY: ctrl_o.do_query = 1'b1;
          bdq_pkg::OP_POP:   ctrl_o.do_pop_rd = 1'b1;
          default: ;
        endcase
      end
      bdq_pkg::ST_SCAN: begin
        ctrl_o.scan_inc = 1'b1;
        if (stat_i.hit) begin
          ctrl_o.do_alloc = (stat_i.op == bdq_pkg::OP_ALLOC);
          ctrl_o.do_key   = (stat_i.op == bdq_pkg::OP_KEY);
        end
      end
      bdq_pkg::ST_POP: ctrl_o.do_pop = 1'b1;
      bdq_pkg::ST_DONE: ctrl_o.finish = 1'b1;
      default: ;
    endcase
  end
endmodule

// ----- design/bdq_dp.sv -----
// ----------------------------------------------------------------------------
// Button debounce event queue datapath
// Slot table, scan counter, event ring and result registers.
// ----------------------------------------------------------------------------
module bdq_dp #(
  parameter int SlotCount = 32,
  parameter int RingDepth = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bdq_pkg::ctrl_t ctrl_i,
  output bdq_pkg::stat_t stat_o,
  input  logic [2:0]     mode_i,
  input  logic [4:0]     slot_i,
  input  logic [7:0]     pin_i,
  input  logic [7:0]     key_id_i,
  input  logic [15:0]    debounce_ms_i,
  input  logic           key_down_i,
  input  logic [31:0]    now_ms_i,
  output logic           done_o,
  output logic           success_o,
  output logic [4:0]     given_slot_o,
  output logic           button_down_o,
  output logic [4:0]     event_slot_o,
  output logic           event_press_o,
  output logic [31:0]    event_time_o,
  output logic [7:0]     event_pin_o,
  output logic [7:0]     event_key_o
);
  localparam int SW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int RW = $clog2(RingDepth);
  localparam int EW = 54;

  logic [2:0]  mode_q;
  logic [4:0]  slot_q;
  logic [7:0]  pin_q, key_q;
  logic [15:0] deb_q;
  logic        down_q;
  logic [31:0] now_q;

  logic [SlotCount-1:0] used_q;
  logic [7:0]  spin_q [SlotCount];
  logic [7:0]  skey_q [SlotCount];
  logic [15:0] sdeb_q [SlotCount];
  logic        sprs_q [SlotCount];
  logic [31:0] stime_q [SlotCount];

  logic [SW-1:0] idx_q;
  logic [RW-1:0] head_q, tail_q;
  logic [RW-1:0] head_nx, tail_nx;
  logic          sel_ok;
  logic [SW-1:0] qsel;
  logic          match, fire;
  logic [31:0]   elapsed;
  logic          hit;
  logic [EW-1:0] ring_wd, ring_rd;

  logic          res_ok_q, res_bd_q, done_q;
  logic [4:0]    res_gs_q;

  assign head_nx = (head_q == RW'(RingDepth - 1)) ? '0 : head_q + 1'b1;
  assign tail_nx = (tail_q == RW'(RingDepth - 1)) ? '0 : tail_q + 1'b1;

  assign sel_ok  = (32'(slot_q) < 32'(SlotCount));
  assign qsel    = SW'(slot_q);
  assign match   = used_q[idx_q] && (skey_q[idx_q] == key_q);
  assign elapsed = now_q - stime_q[idx_q];
  assign fire    = (elapsed >= 32'(sdeb_q[idx_q])) && (sprs_q[idx_q] != down_q);
  assign hit     = (mode_q == 3'(bdq_pkg::OP_ALLOC)) ? !used_q[idx_q] : match;

  assign stat_o.op         = bdq_pkg::op_e'(mode_q);
  assign stat_o.hit        = hit;
  assign stat_o.scan_last  = (32'(idx_q) == 32'(SlotCount - 1));
  assign stat_o.ring_empty = (head_q == tail_q);

  assign ring_wd = {5'(idx_q), down_q, now_q, spin_q[idx_q], skey_q[idx_q]};

  bdq_ram #(.Width(EW), .Depth(RingDepth)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.do_key && fire),
    .waddr_i (tail_q),
    .wdata_i (ring_wd),
    .raddr_i (head_q),
    .rdata_o (ring_rd)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      mode_q <= mode_i;
      slot_q <= slot_i;
      pin_q  <= pin_i;
      key_q  <= key_id_i;
      deb_q  <= debounce_ms_i;
      down_q <= key_down_i;
      now_q  <= now_ms_i;
    end
    if (ctrl_i.do_alloc) begin
      spin_q[idx_q]  <= pin_q;
      skey_q[idx_q]  <= key_q;
      sdeb_q[idx_q]  <= deb_q;
      sprs_q[idx_q]  <= 1'b0;
      stime_q[idx_q] <= '0;
    end
    if (ctrl_i.do_key && fire) begin
      sprs_q[idx_q]  <= down_q;
      stime_q[idx_q] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      idx_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      res_ok_q <= 1'b0;
      res_bd_q <= 1'b0;
      res_gs_q <= '0;
      done_q   <= 1'b0;
      event_slot_o  <= '0;
      event_press_o <= 1'b0;
      event_time_o  <= '0;
      event_pin_o   <= '0;
      event_key_o   <= '0;
    end else begin
      done_q <= ctrl_i.finish;
      if (ctrl_i.latch) begin
        res_ok_q <= 1'b0;
        res_bd_q <= 1'b0;
        res_gs_q <= '0;
        event_slot_o  <= '0;
        event_press_o <= 1'b0;
        event_time_o  <= '0;
        event_pin_o   <= '0;
        event_key_o   <= '0;
      end
      if (ctrl_i.scan_clr) idx_q <= '0;
      else if (ctrl_i.scan_inc) idx_q <= idx_q + 1'b1;
      if (ctrl_i.do_free && sel_ok) used_q[qsel] <= 1'b0;
      if (ctrl_i.do_query && sel_ok && used_q[qsel]) res_bd_q <= sprs_q[qsel];
      if (ctrl_i.do_alloc) begin
        used_q[idx_q] <= 1'b1;
        res_ok_q <= 1'b1;
        res_gs_q <= 5'(idx_q);
      end
      if (ctrl_i.do_key && fire) begin
        res_ok_q <= 1'b1;
        tail_q   <= tail_nx;
        if (tail_nx == head_q) head_q <= head_nx;
      end
      if (ctrl_i.do_pop) begin
        res_ok_q <= 1'b1;
        head_q   <= head_nx;
        {event_slot_o, event_press_o, event_time_o, event_pin_o, event_key_o} <= ring_rd;
      end
      if (ctrl_i.do_clear) begin
        head_q <= '0;
        tail_q <= '0;
      end
    end
  end

  assign done_o        = done_q;
  assign success_o     = res_ok_q;
  assign given_slot_o  = res_gs_q;
  assign button_down_o = res_bd_q;
endmodule

// ----- design/button_debounce_event_queue_top.sv -----
// ----------------------------------------------------------------------------
// Button debounce event queue top level
// Slot table with debounce and an event ring, one operation per start beat.
// Free, query, clear and a pop of an empty ring pass from the check state to
// done; a pop that returns an event adds the pop state, and allocate and key
// events scan the slots in order until a hit or the last slot.
// The slot scan loop sets the rate; the next beat is taken in the result cycle.
// Reset frees all slots and empties the ring; the receiver cannot stall.
// ----------------------------------------------------------------------------
module button_debounce_event_queue_top #(
  parameter int SLOT_COUNT = 32,
  parameter int RING_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [4:0]  slot_i,
  input  logic [7:0]  pin_i,
  input  logic [7:0]  key_id_i,
  input  logic [15:0] debounce_ms_i,
  input  logic        key_down_i,
  input  logic [31:0] now_ms_i,
  output logic        done_o,
  output logic        success_o,
  output logic [4:0]  given_slot_o,
  output logic        button_down_o,
  output logic [4:0]  event_slot_o,
  output logic        event_press_o,
  output logic [31:0] event_time_o,
  output logic [7:0]  event_pin_o,
  output logic [7:0]  event_key_o
);
  bdq_pkg::ctrl_t ctrl;
  bdq_pkg::stat_t stat;
  logic           busy_c;

  bdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_c)
  );

  bdq_dp #(.SlotCount(SLOT_COUNT), .RingDepth(RING_DEPTH)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i(ctrl), .stat_o(stat),
    .mode_i, .slot_i, .pin_i, .key_id_i, .debounce_ms_i, .key_down_i, .now_ms_i,
    .done_o, .success_o, .given_slot_o, .button_down_o,
    .event_slot_o, .event_press_o, .event_time_o, .event_pin_o, .event_key_o
  );

  assign busy = busy_c;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_c)) else $error("done without operation");
  a_no_start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy_c) else $error("start not taken");
  a_success_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && given_slot_o != 5'd0) |-> success_o) else $error("slot without success");
endmodule
